FILE: sv/polyline_point_at_distance_macros.svh
// ----------------------------------------------------------------------------
// polyline point at distance: assertion macros
// Shared clocked assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_POINT_AT_DISTANCE_MACROS_SVH
`define POLYLINE_POINT_AT_DISTANCE_MACROS_SVH

// same-cycle implication
`define PPAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ppad_pkg.sv
// ----------------------------------------------------------------------------
// ppad_pkg
// Types and fixed constants of the polyline point-at-distance block.
// ----------------------------------------------------------------------------
package ppad_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DECIDE,
    ST_SCALE,
    ST_DIVIDE,
    ST_PLACE,
    ST_ARM,
    ST_NORM,
    ST_CORDIC,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef logic signed [44:0] crd_t;

  localparam logic [5:0] MUL_LAST  = 6'd32;
  localparam logic [5:0] ROOT_LAST = 6'd33;
  localparam logic [5:0] DIV_LAST  = 6'd32;
  localparam logic [5:0] CRD_LAST  = 6'd19;

  localparam logic signed [24:0] PI_Q20    = 25'sd3294199;
  localparam logic signed [18:0] ANG_MAX   = 19'sd25736;
  localparam logic [46:0]        TRAVEL_MAX = '1;
  localparam crd_t               NORM_LIM  = 45'sh100_0000_0000;

  function automatic logic signed [24:0] atan_q20(input logic [4:0] i);
    logic signed [24:0] a;
    unique case (i)
      5'd0:    a = 25'sd823550;
      5'd1:    a = 25'sd486170;
      5'd2:    a = 25'sd256879;
      5'd3:    a = 25'sd130396;
      5'd4:    a = 25'sd65451;
      5'd5:    a = 25'sd32757;
      5'd6:    a = 25'sd16383;
      5'd7:    a = 25'sd8192;
      5'd8:    a = 25'sd4096;
      5'd9:    a = 25'sd2048;
      5'd10:   a = 25'sd1024;
      5'd11:   a = 25'sd512;
      5'd12:   a = 25'sd256;
      5'd13:   a = 25'sd128;
      5'd14:   a = 25'sd64;
      5'd15:   a = 25'sd32;
      5'd16:   a = 25'sd16;
      5'd17:   a = 25'sd8;
      5'd18:   a = 25'sd4;
      5'd19:   a = 25'sd2;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/polyline_point_at_distance.sv
// ----------------------------------------------------------------------------
// polyline_point_at_distance
// Streams 3D polyline vertices and reports the point at a wanted arc length,
// with its segment number, heading and slope.
// ----------------------------------------------------------------------------
// A vertex that opens a line (unless it also closes it), or one that
// follows a line already resolved, is taken while the block stays idle.
// Any other vertex holds the input through the bit-serial squaring of the
// three differences and the two root extractions, which run one result bit
// per cycle. The vertex that reaches the wanted distance goes on through the
// serial product, the restoring divide (three coordinate lanes side by side)
// and, per angle, normalizing and 20 iterations on the shared CORDIC. A
// result waits in an output register while the next vertex is taken.
module polyline_point_at_distance #(
  parameter int unsigned MAX_SEGMENTS = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic signed [31:0] in_vertex_z,
  input  logic signed [47:0] in_target_distance,
  input  logic               in_first_vertex,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic        [15:0] out_segment_number,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [15:0] out_heading_angle,
  output logic signed [15:0] out_slope_angle
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

  ppad_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ang_sel_r, ang_sel_nxt;

  logic signed [31:0] prev_r [3], prev_nxt [3];
  logic signed [31:0] vtx_r [3], vtx_nxt [3];
  logic               vtx_last_r, vtx_last_nxt;
  logic signed [32:0] d_r [3], d_nxt [3];
  logic [46:0]        trav_r, trav_nxt;
  logic signed [47:0] wanted_r, wanted_nxt;
  logic [SEG_W-1:0]   segcnt_r, segcnt_nxt;
  logic               located_r, located_nxt;

  logic [66:0] mcand_r [3], mcand_nxt [3];
  logic [32:0] mplier_r [3], mplier_nxt [3];
  logic [66:0] acc_r [3], acc_nxt [3];

  logic [67:0] rad_r [2], rad_nxt [2];
  logic [35:0] srem_r [2], srem_nxt [2];
  logic [33:0] root_r [2], root_nxt [2];

  logic [33:0] drem_r [3], drem_nxt [3];
  logic [32:0] quo_r [3], quo_nxt [3];

  ppad_pkg::crd_t     ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [24:0] az_r, az_nxt;

  logic               res_found_r, res_found_nxt;
  logic [15:0]        res_seg_r, res_seg_nxt;
  logic signed [31:0] res_p_r [3], res_p_nxt [3];
  logic signed [15:0] res_head_r, res_head_nxt;
  logic signed [15:0] res_slope_r, res_slope_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [15:0]        out_seg_r, out_seg_nxt;
  logic signed [31:0] out_p_r [3], out_p_nxt [3];
  logic signed [15:0] out_head_r, out_head_nxt;
  logic signed [15:0] out_slope_r, out_slope_nxt;

  logic signed [31:0] in_v [3];
  logic signed [32:0] d_new [3];
  logic [32:0]        dmag_new [3];
  logic [32:0]        dmag [3];
  logic [47:0]        tsum;
  logic [46:0]        tnew;
  logic               hit;
  logic signed [48:0] rs;
  logic [33:0]        rest;
  logic [33:0]        seg;
  logic [SEG_W+15:0]  seg_ext;
  logic               below_lim;
  logic               out_free;

  assign in_v[0] = in_vertex_x;
  assign in_v[1] = in_vertex_y;
  assign in_v[2] = in_vertex_z;

  assign seg     = root_r[1];
  assign seg_ext = {16'b0, segcnt_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_new[k]    = $signed({in_v[k][31], in_v[k]}) - $signed({prev_r[k][31], prev_r[k]});
      dmag_new[k] = d_new[k][32] ? (~d_new[k] + 33'd1) : d_new[k];
      dmag[k]     = d_r[k][32] ? (~d_r[k] + 33'd1) : d_r[k];
    end
  end

  // running length and hit test
  always_comb begin
    tsum = {1'b0, trav_r} + {14'b0, seg};
    tnew = tsum[47] ? ppad_pkg::TRAVEL_MAX : tsum[46:0];
    hit  = !wanted_r[47] && (tnew >= wanted_r[46:0]);
    rs   = $signed({wanted_r[47], wanted_r}) - $signed({2'b0, trav_r});
    if (rs[48]) begin
      rest = '0;
    end else if (rs > $signed({15'b0, seg})) begin
      rest = seg;
    end else begin
      rest = rs[33:0];
    end
  end

  assign below_lim = (ax_r < ppad_pkg::NORM_LIM) && (ay_r < ppad_pkg::NORM_LIM) &&
                     (ay_r > -ppad_pkg::NORM_LIM);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppad_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_first_vertex) begin
            state_nxt = in_last_vertex ? ppad_pkg::ST_FINISH : ppad_pkg::ST_IDLE;
          end else if (!located_r) begin
            state_nxt = ppad_pkg::ST_SQUARE;
          end
        end
      end
      ppad_pkg::ST_SQUARE: if (cnt_r == ppad_pkg::MUL_LAST) state_nxt = ppad_pkg::ST_SUM;
      ppad_pkg::ST_SUM:    state_nxt = ppad_pkg::ST_ROOT;
      ppad_pkg::ST_ROOT:   if (cnt_r == ppad_pkg::ROOT_LAST) state_nxt = ppad_pkg::ST_DECIDE;
      ppad_pkg::ST_DECIDE: begin
        if (hit) begin
          state_nxt = ppad_pkg::ST_SCALE;
        end else begin
          state_nxt = vtx_last_r ? ppad_pkg::ST_FINISH : ppad_pkg::ST_IDLE;
        end
      end
      ppad_pkg::ST_SCALE:  if (cnt_r == ppad_pkg::MUL_LAST) state_nxt = ppad_pkg::ST_DIVIDE;
      ppad_pkg::ST_DIVIDE: if (cnt_r == ppad_pkg::DIV_LAST) state_nxt = ppad_pkg::ST_PLACE;
      ppad_pkg::ST_PLACE:  state_nxt = ppad_pkg::ST_ARM;
      ppad_pkg::ST_ARM: begin
        if (ax_r == '0 && ay_r == '0) begin
          state_nxt = ppad_pkg::ST_ROUND;
        end else begin
          state_nxt = ppad_pkg::ST_NORM;
        end
      end
      ppad_pkg::ST_NORM:   if (!below_lim) state_nxt = ppad_pkg::ST_CORDIC;
      ppad_pkg::ST_CORDIC: if (cnt_r == ppad_pkg::CRD_LAST) state_nxt = ppad_pkg::ST_ROUND;
      ppad_pkg::ST_ROUND:  state_nxt = ang_sel_r ? ppad_pkg::ST_FINISH : ppad_pkg::ST_ARM;
      ppad_pkg::ST_FINISH: if (out_free) state_nxt = ppad_pkg::ST_IDLE;
      default:             state_nxt = ppad_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ppad_pkg::ST_IDLE);

  always_comb begin
    logic [37:0]        st;
    logic [37:0]        trial;
    logic [34:0]        dt;
    logic signed [33:0] pt;
    ppad_pkg::crd_t     xs, ys;
    logic signed [25:0] zr;
    logic signed [18:0] ang;

    cnt_nxt       = (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
    ang_sel_nxt   = ang_sel_r;
    prev_nxt      = prev_r;
    vtx_nxt       = vtx_r;
    vtx_last_nxt  = vtx_last_r;
    d_nxt         = d_r;
    trav_nxt      = trav_r;
    wanted_nxt    = wanted_r;
    segcnt_nxt    = segcnt_r;
    located_nxt   = located_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    rad_nxt       = rad_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    res_found_nxt = res_found_r;
    res_seg_nxt   = res_seg_r;
    res_p_nxt     = res_p_r;
    res_head_nxt  = res_head_r;
    res_slope_nxt = res_slope_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_seg_nxt   = out_seg_r;
    out_p_nxt     = out_p_r;
    out_head_nxt  = out_head_r;
    out_slope_nxt = out_slope_r;
    st    = '0;
    trial = '0;
    dt    = '0;
    pt    = '0;
    xs    = '0;
    ys    = '0;
    zr    = '0;
    ang   = '0;

    unique case (state_r)
      ppad_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_first_vertex) begin
            prev_nxt    = in_v;
            trav_nxt    = '0;
            wanted_nxt  = in_target_distance;
            segcnt_nxt  = '0;
            located_nxt = in_last_vertex;
            res_found_nxt = 1'b0;
            res_seg_nxt   = '0;
            res_p_nxt     = in_v;
            res_head_nxt  = '0;
            res_slope_nxt = '0;
          end else begin
            if (segcnt_r < SEG_W'(MAX_SEGMENTS)) segcnt_nxt = segcnt_r + SEG_W'(1);
            if (located_r) begin
              prev_nxt = in_v;
            end else begin
              vtx_nxt      = in_v;
              vtx_last_nxt = in_last_vertex;
              d_nxt        = d_new;
              for (int k = 0; k < 3; k++) begin
                mcand_nxt[k]  = {34'b0, dmag_new[k]};
                mplier_nxt[k] = dmag_new[k];
                acc_nxt[k]    = '0;
              end
            end
          end
        end
      end
      ppad_pkg::ST_SQUARE, ppad_pkg::ST_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          acc_nxt[k]    = acc_r[k] + (mplier_r[k][0] ? mcand_r[k] : 67'd0);
          mcand_nxt[k]  = {mcand_r[k][65:0], 1'b0};
          mplier_nxt[k] = {1'b0, mplier_r[k][32:1]};
          drem_nxt[k]   = acc_nxt[k][66:33];
          quo_nxt[k]    = acc_nxt[k][32:0];
        end
      end
      ppad_pkg::ST_SUM: begin
        rad_nxt[0]  = {1'b0, acc_r[0]} + {1'b0, acc_r[1]};
        rad_nxt[1]  = {1'b0, acc_r[0]} + {1'b0, acc_r[1]} + {1'b0, acc_r[2]};
        srem_nxt[0] = '0;
        srem_nxt[1] = '0;
        root_nxt[0] = '0;
        root_nxt[1] = '0;
      end
      ppad_pkg::ST_ROOT: begin
        for (int j = 0; j < 2; j++) begin
          st    = {srem_r[j], rad_r[j][67:66]};
          trial = {2'b0, root_r[j], 2'b01};
          if (st >= trial) begin
            st          = st - trial;
            root_nxt[j] = {root_r[j][32:0], 1'b1};
          end else begin
            root_nxt[j] = {root_r[j][32:0], 1'b0};
          end
          srem_nxt[j] = st[35:0];
          rad_nxt[j]  = {rad_r[j][65:0], 2'b00};
        end
      end
      ppad_pkg::ST_DECIDE: begin
        trav_nxt = tnew;
        if (hit) begin
          located_nxt   = 1'b1;
          res_found_nxt = 1'b1;
          res_seg_nxt   = seg_ext[15:0];
          for (int k = 0; k < 3; k++) begin
            mcand_nxt[k]  = {33'b0, rest};
            mplier_nxt[k] = dmag[k];
            acc_nxt[k]    = {34'b0, seg[33:1]};
          end
        end else begin
          prev_nxt = vtx_r;
          if (vtx_last_r) begin
            located_nxt   = 1'b1;
            res_found_nxt = 1'b0;
            res_seg_nxt   = '0;
            res_p_nxt     = vtx_r;
            res_head_nxt  = '0;
            res_slope_nxt = '0;
          end
        end
      end
      ppad_pkg::ST_DIVIDE: begin
        for (int k = 0; k < 3; k++) begin
          dt = {drem_r[k], quo_r[k][32]};
          if (dt >= {1'b0, seg}) begin
            dt         = dt - {1'b0, seg};
            quo_nxt[k] = {quo_r[k][31:0], 1'b1};
          end else begin
            quo_nxt[k] = {quo_r[k][31:0], 1'b0};
          end
          drem_nxt[k] = dt[33:0];
        end
      end
      ppad_pkg::ST_PLACE: begin
        for (int k = 0; k < 3; k++) begin
          if (seg == '0) begin
            pt = {{2{prev_r[k][31]}}, prev_r[k]};
          end else if (d_r[k][32]) begin
            pt = $signed({{2{prev_r[k][31]}}, prev_r[k]}) - $signed({1'b0, quo_r[k]});
          end else begin
            pt = $signed({{2{prev_r[k][31]}}, prev_r[k]}) + $signed({1'b0, quo_r[k]});
          end
          res_p_nxt[k] = pt[31:0];
        end
        prev_nxt    = vtx_r;
        ax_nxt      = {{12{d_r[0][32]}}, d_r[0]};
        ay_nxt      = {{12{d_r[1][32]}}, d_r[1]};
        ang_sel_nxt = 1'b0;
      end
      ppad_pkg::ST_ARM: begin
        az_nxt = '0;
        if (ax_r < 0) begin
          az_nxt = (ay_r >= 0) ? ppad_pkg::PI_Q20 : -ppad_pkg::PI_Q20;
          ax_nxt = -ax_r;
          ay_nxt = -ay_r;
        end
      end
      ppad_pkg::ST_NORM: begin
        if (below_lim) begin
          ax_nxt = ax_r <<< 1;
          ay_nxt = ay_r <<< 1;
        end
      end
      ppad_pkg::ST_CORDIC: begin
        xs = ax_r >>> cnt_r[4:0];
        ys = ay_r >>> cnt_r[4:0];
        if (ay_r >= 0) begin
          ax_nxt = ax_r + ys;
          ay_nxt = ay_r - xs;
          az_nxt = az_r + ppad_pkg::atan_q20(cnt_r[4:0]);
        end else begin
          ax_nxt = ax_r - ys;
          ay_nxt = ay_r + xs;
          az_nxt = az_r - ppad_pkg::atan_q20(cnt_r[4:0]);
        end
      end
      ppad_pkg::ST_ROUND: begin
        zr  = {az_r[24], az_r} + 26'sd64;
        ang = zr[25:7];
        if (ang > ppad_pkg::ANG_MAX) ang = ppad_pkg::ANG_MAX;
        if (ang < -ppad_pkg::ANG_MAX) ang = -ppad_pkg::ANG_MAX;
        if (!ang_sel_r) begin
          res_head_nxt = ang[15:0];
          ax_nxt       = {11'b0, root_r[0]};
          ay_nxt       = {{12{d_r[2][32]}}, d_r[2]};
          ang_sel_nxt  = 1'b1;
        end else begin
          res_slope_nxt = ang[15:0];
        end
      end
      ppad_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_seg_nxt   = res_seg_r;
          out_p_nxt     = res_p_r;
          out_head_nxt  = res_head_r;
          out_slope_nxt = res_slope_r;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      located_r   <= 1'b0;
      prev_r      <= '{default: '0};
      trav_r      <= '0;
      wanted_r    <= '0;
      segcnt_r    <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      located_r   <= located_nxt;
      prev_r      <= prev_nxt;
      trav_r      <= trav_nxt;
      wanted_r    <= wanted_nxt;
      segcnt_r    <= segcnt_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_sel_r   <= ang_sel_nxt;
    vtx_r       <= vtx_nxt;
    vtx_last_r  <= vtx_last_nxt;
    d_r         <= d_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    rad_r       <= rad_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    drem_r      <= drem_nxt;
    quo_r       <= quo_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    res_found_r <= res_found_nxt;
    res_seg_r   <= res_seg_nxt;
    res_p_r     <= res_p_nxt;
    res_head_r  <= res_head_nxt;
    res_slope_r <= res_slope_nxt;
    out_found_r <= out_found_nxt;
    out_seg_r   <= out_seg_nxt;
    out_p_r     <= out_p_nxt;
    out_head_r  <= out_head_nxt;
    out_slope_r <= out_slope_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_segment_number = out_seg_r;
  assign out_point_x        = out_p_r[0];
  assign out_point_y        = out_p_r[1];
  assign out_point_z        = out_p_r[2];
  assign out_heading_angle  = out_head_r;
  assign out_slope_angle    = out_slope_r;

endmodule

FILE: sv/ppad_checker.sv
// ----------------------------------------------------------------------------
// ppad_checker
// Port-level checks of the polyline point-at-distance block, bound to it.
// ----------------------------------------------------------------------------
`include "polyline_point_at_distance_macros.svh"

module ppad_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_vertex_x,
  input logic signed [31:0] in_vertex_y,
  input logic signed [31:0] in_vertex_z,
  input logic signed [47:0] in_target_distance,
  input logic               in_first_vertex,
  input logic               in_last_vertex,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_found,
  input logic        [15:0] out_segment_number,
  input logic signed [31:0] out_point_x,
  input logic signed [31:0] out_point_y,
  input logic signed [31:0] out_point_z,
  input logic signed [15:0] out_heading_angle,
  input logic signed [15:0] out_slope_angle
);

  // stalled word stays offered
  `PPAD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")

  // not-found word carries no segment and no angles
  `PPAD_ASSERT_NOW(a_miss_clean, out_valid && !out_found, out_segment_number == 16'd0 && out_heading_angle == 16'sd0 && out_slope_angle == 16'sd0, "not-found word has stray fields")

  // angles stay within plus or minus pi
  `PPAD_ASSERT_NOW(a_ang_range, out_valid, out_heading_angle >= -16'sd25736 && out_heading_angle <= 16'sd25736 && out_slope_angle >= -16'sd25736 && out_slope_angle <= 16'sd25736, "angle out of range")

  // opening vertex alone never blocks the next word
  `PPAD_ASSERT_NXT(a_open_fast, in_valid && !in_stall && in_first_vertex && !in_last_vertex, !in_stall, "stall after opening vertex")

endmodule

bind polyline_point_at_distance ppad_checker u_ppad_checker (.*);

FILE: test/tb_polyline_point_at_distance.sv
// ----------------------------------------------------------------------------
// polyline point at distance testbench
// Streams directed and random polylines into the block with random bursts,
// gaps and receiver stalls, predicts every result word in a scoreboard and
// compares each accepted result field by field.
// ----------------------------------------------------------------------------

class ppad_scoreboard;
  localparam longint unsigned TRAVEL_LIMIT = 64'h7FFF_FFFF_FFFF;
  localparam int unsigned SEG_LIMIT = 65535;

  typedef struct packed {
    logic        found;
    logic [15:0] segment_number;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] heading;
    logic [15:0] slope;
  } point_word_t;

  point_word_t pending[$];
  int errors;
  int hits;
  int misses;
  logic signed [31:0] last_x, last_y, last_z;
  longint unsigned path_len;
  longint signed goal;
  int unsigned seg_cnt;
  bit resolved;

  function new();
    errors = 0;
    hits = 0;
    misses = 0;
    last_x = 0;
    last_y = 0;
    last_z = 0;
    path_len = 0;
    goal = 0;
    seg_cnt = 0;
    resolved = 0;
  endfunction

  function automatic longint unsigned root(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int s = 35; s >= 0; s--) begin
      t = r | (64'd1 << s);
      if (128'(t) * 128'(t) <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint signed arctan(longint signed yi, longint signed xi);
    longint signed x, y, z, xs, ys, r;
    longint unsigned mx, my;
    longint signed tbl[20];
    x = xi;
    y = yi;
    z = 0;
    tbl = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
            1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 3294199 : -3294199;
      x = -x;
      y = -y;
    end
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    if (my > mx) mx = my;
    while (mx < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      mx = mx * 2;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + tbl[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - tbl[i];
      end
    end
    r = (z + 64) >>> 7;
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  function automatic logic [31:0] place(logic signed [31:0] start, longint signed d,
                                        longint unsigned rest, longint unsigned seg);
    logic [127:0] num;
    longint unsigned off;
    longint unsigned ad;
    if (seg == 0) return start;
    ad = d < 0 ? -d : d;
    num = 128'(rest) * 128'(ad) + 128'(seg >> 1);
    off = 64'(num / 128'(seg));
    return d < 0 ? 32'(longint'(start) - longint'(off)) : 32'(longint'(start) + longint'(off));
  endfunction

  function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                            logic signed [31:0] vz, logic signed [47:0] target,
                            bit first, bit last);
    point_word_t w;
    longint signed dx, dy, dz, rs;
    longint unsigned dxy, seg, tnew, rest;
    logic [127:0] sxy;
    if (first) begin
      last_x = vx;
      last_y = vy;
      last_z = vz;
      path_len = 0;
      goal = target;
      seg_cnt = 0;
      resolved = 0;
      if (last) begin
        w = '{1'b0, 16'd0, vx, vy, vz, 16'd0, 16'd0};
        pending.push_back(w);
        misses++;
        resolved = 1;
      end
      return;
    end
    dx = longint'(vx) - longint'(last_x);
    dy = longint'(vy) - longint'(last_y);
    dz = longint'(vz) - longint'(last_z);
    if (seg_cnt < SEG_LIMIT) seg_cnt++;
    sxy = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    dxy = root(sxy);
    seg = root(sxy + 128'(dz) * 128'(dz));
    tnew = path_len + seg;
    if (tnew > TRAVEL_LIMIT) tnew = TRAVEL_LIMIT;
    if (!resolved && goal >= 0 && longint'(tnew) >= goal) begin
      rs = goal - longint'(path_len);
      rest = rs < 0 ? 0 : rs;
      if (rest > seg) rest = seg;
      w.found = 1'b1;
      w.segment_number = seg_cnt[15:0];
      w.px = place(last_x, dx, rest, seg);
      w.py = place(last_y, dy, rest, seg);
      w.pz = place(last_z, dz, rest, seg);
      w.heading = 16'(arctan(dy, dx));
      w.slope = 16'(arctan(dz, longint'(dxy)));
      pending.push_back(w);
      hits++;
      resolved = 1;
    end else if (!resolved && last) begin
      w = '{1'b0, 16'd0, vx, vy, vz, 16'd0, 16'd0};
      pending.push_back(w);
      misses++;
      resolved = 1;
    end
    if (last) resolved = 1;
    last_x = vx;
    last_y = vy;
    last_z = vz;
    path_len = tnew;
  endfunction

  function void check_word(point_word_t got);
    point_word_t want;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d actual %0d", want.found, got.found);
      errors++;
    end
    if (got.segment_number !== want.segment_number) begin
      $error("segment_number: expected %0d actual %0d", want.segment_number,
             got.segment_number);
      errors++;
    end
    if (got.px !== want.px) begin
      $error("point_x: expected %0d actual %0d", $signed(want.px), $signed(got.px));
      errors++;
    end
    if (got.py !== want.py) begin
      $error("point_y: expected %0d actual %0d", $signed(want.py), $signed(got.py));
      errors++;
    end
    if (got.pz !== want.pz) begin
      $error("point_z: expected %0d actual %0d", $signed(want.pz), $signed(got.pz));
      errors++;
    end
    if (got.heading !== want.heading) begin
      $error("heading_angle: expected %0d actual %0d", $signed(want.heading),
             $signed(got.heading));
      errors++;
    end
    if (got.slope !== want.slope) begin
      $error("slope_angle: expected %0d actual %0d", $signed(want.slope),
             $signed(got.slope));
      errors++;
    end
  endfunction
endclass

module tb_polyline_point_at_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_vertex_x = '0;
  logic signed [31:0] in_vertex_y = '0;
  logic signed [31:0] in_vertex_z = '0;
  logic signed [47:0] in_target_distance = '0;
  logic in_first_vertex = 1'b0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [15:0] out_segment_number;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic signed [15:0] out_heading_angle, out_slope_angle;

  ppad_scoreboard board = new();
  int sent = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  polyline_point_at_distance dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("polyline_point_at_distance regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word('{out_found, out_segment_number, out_point_x, out_point_y,
                         out_point_z, out_heading_angle, out_slope_angle});
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (cycles % 2000 < 600) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (sent >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (5000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [47:0] d,
                             bit first, bit last);
    in_valid <= 1'b1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_vertex_z <= z;
    in_target_distance <= d;
    in_first_vertex <= first;
    in_last_vertex <= last;
    do @(posedge clk); while (in_stall);
    board.note_vertex(x, y, z, d, first, last);
    sent++;
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 4095)) - 2048;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic send_line();
    int n, mode;
    longint signed d;
    mode = $urandom_range(0, 2);
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 5))
      0: d = -longint'($urandom_range(1, 1000));
      1: d = {$urandom, $urandom} >>> 16;
      2: d = 0;
      default: d = $urandom_range(0, 3000000);
    endcase
    for (int i = 0; i < n; i++)
      send_vertex(coord(mode), coord(mode), coord(mode), 48'(d), i == 0, i == n - 1);
    if ($urandom_range(0, 9) == 0)
      send_vertex(coord(mode), coord(mode), coord(mode), 48'({$urandom, $urandom}), 0,
                  1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // vertices before any opening mark, then extremes and special cases
    send_vertex(32'sd256, 32'sd0, 32'sd0, 48'sd0, 0, 0);
    send_vertex(32'sd5, 32'sd5, 32'sd5, 48'sd0, 1, 1);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 48'sh7FFFFFFFFFFF, 1, 0);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 48'sh800000000000, 0, 1);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 48'sh800000000000, 1, 0);
    send_vertex(32'sd100, 32'sd100, 32'sd100, 48'sd0, 0, 1);
    send_vertex(32'sd7, 32'sd7, 32'sd7, 48'sd0, 1, 0);
    send_vertex(32'sd7, 32'sd7, 32'sd7, 48'sd0, 0, 0);
    send_vertex(32'sd9, 32'sd7, 32'sd7, 48'sd0, 0, 1);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 48'sd1000, 1, 0);
    send_vertex(-32'sd300, 32'sd400, -32'sd100, 48'sd0, 0, 0);
    send_vertex(-32'sd600, -32'sd400, 32'sd900, 48'sd0, 0, 0);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 48'sd0, 0, 1);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 48'sd0, 0, 1);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 48'sh7FFFFFFFFFFF, 1, 0);
    send_vertex(32'sd0, 32'sd0, -32'sd50, 48'sd0, 0, 0);
    send_vertex(-32'sd10, 32'sd0, -32'sd50, 48'sd0, 0, 1);
    while (sent < 1600) send_line();
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d vertices sent; %0d located points and %0d misses predicted",
             sent, board.hits, board.misses);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("polyline_point_at_distance regression: pass");
    else
      $display("polyline_point_at_distance regression: fail");
    $finish;
  end
endmodule
